// ===== rtl/core/tupd_pkg.sv =====
// Shared types and constants for the two-user preamble peak detector.
// Holds the controller/datapath command and status structs and the output codes.
// No dependencies.
`timescale 1ns / 1ps

package tupd_pkg;

	localparam int PREAMBLE_LEN_DEF = 64;
	localparam int SAMPLE_W         = 16;
	localparam int CFG_W            = 12;
	localparam int CFG_IDX_W        = 1;
	localparam int CNT_W            = 14;
	localparam int POS_W            = 32;
	localparam int TIDX_W           = 6;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DELAY    = 1'b1;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_A,
		MODE_B,
		MODE_BOTH
	} mode_t;

	typedef enum logic [1:0] {
		TAG_NONE,
		TAG_SINGLE,
		TAG_MULTI
	} tag_t;

	typedef struct packed {
		logic capture;
		logic decide;
		logic corr_start;
		logic corr_user;
		logic apply_onlyb;
		logic apply_a;
		logic apply_b;
		logic apply_hit;
		logic finish;
	} tupd_ctl_t;

	typedef struct packed {
		logic is_load;
		logic br_onlyb;
		logic br_both;
		logic need_onlyb;
		logic need_a;
		logic need_b;
		logic corr_done;
		logic corr_hit;
	} tupd_stat_t;

endpackage

// ===== rtl/core/tupd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tupd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/tupd_corr.sv =====
// Normalized cross-correlation unit: one MAC per cycle over the window,
// then a bit-serial multiplier for |c|^2 and Ek*Es. Depends on tupd_pkg.
`timescale 1ns / 1ps

module tupd_corr #(
	parameter int N = tupd_pkg::PREAMBLE_LEN_DEF,
	localparam int LW = $clog2(N)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            user,
	input  logic [LW-1:0]                   ptr,
	output logic [LW:0]                     pre_raddr,
	output logic [LW-1:0]                   win_raddr,
	input  logic [2*tupd_pkg::SAMPLE_W-1:0] pre_rdata,
	input  logic [2*tupd_pkg::SAMPLE_W-1:0] win_rdata,
	input  logic                            win_vld_s1,
	output logic                            done,
	output logic                            hit
);
	import tupd_pkg::*;

	localparam int SW   = SAMPLE_W;
	localparam int ACC_W = 2 * SW + LW + 2;
	localparam int P_W  = 2 * ACC_W + 7;
	localparam int ST_W = $clog2(ACC_W);

	typedef enum logic [3:0] {
		C_IDLE,
		C_MAC,
		C_SQ_RE,
		C_SQ_IM,
		C_SCL,
		C_PROD,
		C_SCR,
		C_CMP
	} cstate_t;

	cstate_t state_q;
	logic [LW:0]             iss_q;
	logic                    user_q;
	logic [LW-1:0]           ptr_q;
	logic                    rd_s1;
	logic                    mul_s2;
	logic signed [2*SW:0]    p_re_s2, p_im_s2, p_kk_s2, p_ss_s2;
	logic signed [ACC_W-1:0] cre_q, cim_q, ek_q, es_q;
	logic [P_W-1:0]          mc_q, acc_q, l100_q, r49_q;
	logic [ACC_W-1:0]        mp_q;
	logic [ST_W-1:0]         step_q;
	logic                    last_step;
	logic [LW:0]             wsum;
	logic signed [SW-1:0]    kr, ki, sr, si;

	function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-1:0] r;
		r = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
		return r;
	endfunction

	// window index wraps modulo the preamble length
	always_comb begin
		wsum = (LW+1)'(ptr_q) + (LW+1)'(iss_q[LW-1:0]);
		if (wsum >= (LW+1)'(N)) begin
			wsum = wsum - (LW+1)'(N);
		end
		win_raddr = wsum[LW-1:0];
		pre_raddr = (LW+1)'(iss_q[LW-1:0]) + (user_q ? (LW+1)'(N) : '0);
	end

	always_comb begin
		kr = signed'(pre_rdata[2*SW-1:SW]);
		ki = signed'(pre_rdata[SW-1:0]);
		sr = win_vld_s1 ? signed'(win_rdata[2*SW-1:SW]) : '0;
		si = win_vld_s1 ? signed'(win_rdata[SW-1:0]) : '0;
	end

	assign last_step = (step_q == ST_W'(ACC_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			iss_q   <= '0;
			user_q  <= 1'b0;
			ptr_q   <= '0;
			rd_s1   <= 1'b0;
			mul_s2  <= 1'b0;
			done    <= 1'b0;
			hit     <= 1'b0;
			step_q  <= '0;
		end else begin
			done   <= 1'b0;
			rd_s1  <= (state_q == C_MAC) && (iss_q < (LW+1)'(N));
			mul_s2 <= rd_s1;
			p_re_s2 <= kr * sr + ki * si;
			p_im_s2 <= kr * si - ki * sr;
			p_kk_s2 <= kr * kr + ki * ki;
			p_ss_s2 <= sr * sr + si * si;
			if (mul_s2) begin
				cre_q <= cre_q + ACC_W'(p_re_s2);
				cim_q <= cim_q + ACC_W'(p_im_s2);
				ek_q  <= ek_q + ACC_W'(p_kk_s2);
				es_q  <= es_q + ACC_W'(p_ss_s2);
			end
			case (state_q)
				C_IDLE: begin
					if (start) begin
						user_q  <= user;
						ptr_q   <= ptr;
						iss_q   <= '0;
						cre_q   <= '0;
						cim_q   <= '0;
						ek_q    <= '0;
						es_q    <= '0;
						state_q <= C_MAC;
					end
				end
				C_MAC: begin
					if (iss_q < (LW+1)'(N)) begin
						iss_q <= iss_q + 1'b1;
					end else if (!rd_s1 && !mul_s2) begin
						mc_q    <= P_W'(mag(cre_q));
						mp_q    <= mag(cre_q);
						acc_q   <= '0;
						step_q  <= '0;
						state_q <= C_SQ_RE;
					end
				end
				C_SQ_RE, C_SQ_IM, C_PROD: begin
					acc_q  <= mp_q[0] ? acc_q + mc_q : acc_q;
					mc_q   <= mc_q << 1;
					mp_q   <= mp_q >> 1;
					step_q <= step_q + 1'b1;
					if (last_step) begin
						step_q <= '0;
						if (state_q == C_SQ_RE) begin
							mc_q    <= P_W'(mag(cim_q));
							mp_q    <= mag(cim_q);
							state_q <= C_SQ_IM;
						end else if (state_q == C_SQ_IM) begin
							state_q <= C_SCL;
						end else begin
							state_q <= C_SCR;
						end
					end
				end
				C_SCL: begin
					l100_q  <= (acc_q << 6) + (acc_q << 5) + (acc_q << 2);
					mc_q    <= P_W'(ek_q);
					mp_q    <= es_q;
					acc_q   <= '0;
					state_q <= C_PROD;
				end
				C_SCR: begin
					r49_q   <= (acc_q << 5) + (acc_q << 4) + acc_q;
					state_q <= C_CMP;
				end
				C_CMP: begin
					hit     <= (l100_q > r49_q);
					done    <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/tupd_dp.sv =====
// Datapath: sample window, preamble store, search bookkeeping and output beat.
// Depends on tupd_pkg, tupd_ram and tupd_corr.
`timescale 1ns / 1ps

module tupd_dp #(
	parameter int N = tupd_pkg::PREAMBLE_LEN_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tupd_pkg::tupd_ctl_t                  ctl,
	output tupd_pkg::tupd_stat_t                 stat,
	input  logic                                 cfg_we,
	input  logic [tupd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tupd_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 cmd,
	input  logic                                 auto_peak,
	input  logic signed [tupd_pkg::SAMPLE_W-1:0] sample_re,
	input  logic signed [tupd_pkg::SAMPLE_W-1:0] sample_im,
	input  logic signed [tupd_pkg::SAMPLE_W-1:0] cfo_in,
	input  logic                                 table_sel,
	input  logic [tupd_pkg::TIDX_W-1:0]          table_index,
	input  logic signed [tupd_pkg::SAMPLE_W-1:0] coef_re,
	input  logic signed [tupd_pkg::SAMPLE_W-1:0] coef_im,
	output logic [1:0]                           peak_mode,
	output logic [1:0]                           tag_kind,
	output logic signed [tupd_pkg::SAMPLE_W-1:0] cfo_out
);
	import tupd_pkg::*;

	localparam int LW = $clog2(N);
	localparam int CW = CNT_W + 1;

	typedef enum logic [1:0] {
		PH_NO_PEAK,
		PH_AUTO_PEAK,
		PH_HAVE_PEAK
	} sph_t;

	typedef enum logic [1:0] {
		WIN_NONE,
		WIN_ONLYB,
		WIN_BOTH
	} wph_t;

	logic [CFG_W-1:0]    sl_q, pd_q;
	logic [LW-1:0]       ptr_q;
	logic [POS_W-1:0]    sp_q, emit_q;
	sph_t                sph_q, sph_n;
	wph_t                wph_q;
	logic [CNT_W-1:0]    cnt_q, cnt_inc;
	logic                found_a_q, found_b_q;
	logic [SAMPLE_W-1:0] cfo_a_q, cfo_b_q, held_q, held_n, cfo_q;
	mode_t               mode_q, mode_n, mode_o;
	tag_t                tag_o;
	logic [SAMPLE_W-1:0] cfo_o;
	logic                cmd_q, act_q;
	logic [N-1:0]        win_vld_q;
	logic                win_vld_s1;
	logic [CW-1:0]       c15, sl15, pd15, lim1, lim2;
	logic signed [SAMPLE_W:0] avg;

	logic                pre_we, win_we;
	logic [LW:0]         pre_waddr, pre_raddr;
	logic [LW-1:0]       win_raddr;
	logic [2*SAMPLE_W-1:0] pre_rdata, win_rdata;
	logic                corr_done, corr_hit;

	assign win_we    = ctl.capture && (cmd == CMD_SAMPLE);
	assign pre_we    = ctl.capture && (cmd == CMD_LOAD) && (32'(table_index) < N);
	assign pre_waddr = (LW+1)'(table_index) + (table_sel ? (LW+1)'(N) : '0);

	tupd_ram #(.WIDTH(2*SAMPLE_W), .DEPTH(N)) u_win (
		.clk  (clk),
		.we   (win_we),
		.waddr(ptr_q),
		.wdata({sample_re, sample_im}),
		.raddr(win_raddr),
		.rdata(win_rdata)
	);

	tupd_ram #(.WIDTH(2*SAMPLE_W), .DEPTH(2*N)) u_pre (
		.clk  (clk),
		.we   (pre_we),
		.waddr(pre_waddr),
		.wdata({coef_re, coef_im}),
		.raddr(pre_raddr),
		.rdata(pre_rdata)
	);

	tupd_corr #(.N(N)) u_corr (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.corr_start),
		.user      (ctl.corr_user),
		.ptr       (ptr_q),
		.pre_raddr (pre_raddr),
		.win_raddr (win_raddr),
		.pre_rdata (pre_rdata),
		.win_rdata (win_rdata),
		.win_vld_s1(win_vld_s1),
		.done      (corr_done),
		.hit       (corr_hit)
	);

	// window limits, one bit wider than the counter
	always_comb begin
		c15  = CW'(cnt_q);
		sl15 = CW'(sl_q);
		pd15 = CW'(pd_q);
		lim1 = sl15 + pd15;
		lim2 = (sl15 << 1) + pd15;
	end

	always_comb begin
		stat.is_load    = (cmd_q == CMD_LOAD);
		stat.br_onlyb   = (sph_q == PH_AUTO_PEAK) && (wph_q == WIN_ONLYB);
		stat.br_both    = (sph_q == PH_AUTO_PEAK) && (wph_q == WIN_BOTH);
		stat.need_onlyb = (c15 < pd15) && !found_b_q;
		stat.need_a     = (c15 > sl15) && (c15 < lim1) && !found_a_q;
		stat.need_b     = (c15 > (sl15 << 1)) && (c15 < lim2) && !found_b_q;
		stat.corr_done  = corr_done;
		stat.corr_hit   = corr_hit;
	end

	// end-of-sample update: counter, timeout to single-user A, emit
	always_comb begin
		cnt_inc = (cnt_q < CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
		mode_n  = mode_q;
		sph_n   = sph_q;
		if (act_q && (CW'(cnt_inc) > lim2) && found_a_q) begin
			mode_n = MODE_A;
			sph_n  = PH_HAVE_PEAK;
		end
		avg    = ($signed({cfo_a_q[SAMPLE_W-1], cfo_a_q}) +
			$signed({cfo_b_q[SAMPLE_W-1], cfo_b_q})) >>> 1;
		held_n = held_q;
		mode_o = MODE_NONE;
		tag_o  = TAG_NONE;
		cfo_o  = '0;
		if (sph_n == PH_HAVE_PEAK) begin
			if (sp_q == emit_q) begin
				mode_o = mode_n;
				if (mode_n == MODE_BOTH) begin
					held_n = avg[SAMPLE_W-1:0];
					tag_o  = TAG_MULTI;
				end else if (mode_n != MODE_NONE) begin
					held_n = (mode_n == MODE_B) ? cfo_b_q : cfo_a_q;
					tag_o  = TAG_SINGLE;
				end
			end
			if (sp_q >= emit_q) begin
				cfo_o = held_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sl_q       <= CFG_W'(80);
			pd_q       <= CFG_W'(160);
			ptr_q      <= '0;
			sp_q       <= '0;
			emit_q     <= '1;
			sph_q      <= PH_NO_PEAK;
			wph_q      <= WIN_NONE;
			cnt_q      <= '0;
			found_a_q  <= 1'b0;
			found_b_q  <= 1'b0;
			cfo_a_q    <= '0;
			cfo_b_q    <= '0;
			held_q     <= '0;
			mode_q     <= MODE_NONE;
			cmd_q      <= CMD_SAMPLE;
			act_q      <= 1'b0;
			win_vld_q  <= '0;
			win_vld_s1 <= 1'b0;
		end else begin
			win_vld_s1 <= win_vld_q[win_raddr];
			if (cfg_we) begin
				case (cfg_index)
					CFG_SYMBOL_LENGTH: sl_q <= cfg_data;
					CFG_PEAK_DELAY:    pd_q <= cfg_data;
					default: ;
				endcase
			end
			if (ctl.capture) begin
				cmd_q <= cmd;
				if (cmd == CMD_SAMPLE) begin
					win_vld_q[ptr_q] <= 1'b1;
					ptr_q <= (ptr_q == LW'(N - 1)) ? '0 : ptr_q + 1'b1;
					if (auto_peak) begin
						sph_q     <= PH_AUTO_PEAK;
						cnt_q     <= '0;
						found_a_q <= 1'b0;
						found_b_q <= 1'b0;
						wph_q     <= WIN_ONLYB;
						mode_q    <= MODE_NONE;
					end
				end
			end
			if (ctl.decide) begin
				act_q <= (sph_q == PH_AUTO_PEAK);
			end
			if (ctl.apply_onlyb) begin
				if (ctl.apply_hit) begin
					found_b_q <= 1'b1;
					wph_q     <= WIN_NONE;
					cfo_b_q   <= cfo_q;
					emit_q    <= sp_q + POS_W'(pd_q);
					sph_q     <= PH_HAVE_PEAK;
					mode_q    <= MODE_B;
				end
				if (c15 >= pd15) begin
					wph_q <= WIN_BOTH;
				end
			end
			if (ctl.apply_a && ctl.apply_hit) begin
				found_a_q <= 1'b1;
				cfo_a_q   <= cfo_q;
				emit_q    <= sp_q + POS_W'(sl_q) + POS_W'(pd_q);
				found_b_q <= 1'b0;
			end
			if (ctl.apply_b && ctl.apply_hit) begin
				found_b_q <= 1'b1;
				cfo_b_q   <= cfo_q;
				emit_q    <= sp_q + POS_W'(pd_q);
				if (found_a_q) begin
					mode_q <= MODE_BOTH;
				end
				sph_q <= PH_HAVE_PEAK;
			end
			if (ctl.finish && (cmd_q == CMD_SAMPLE)) begin
				if (act_q) begin
					cnt_q <= cnt_inc;
				end
				mode_q <= mode_n;
				sph_q  <= sph_n;
				held_q <= held_n;
				sp_q   <= sp_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cfo_q <= cfo_in;
		end
		if (ctl.finish) begin
			if (cmd_q == CMD_LOAD) begin
				peak_mode <= MODE_NONE;
				tag_kind  <= TAG_NONE;
				cfo_out   <= '0;
			end else begin
				peak_mode <= mode_o;
				tag_kind  <= tag_o;
				cfo_out   <= cfo_o;
			end
		end
	end

endmodule

// ===== rtl/core/tupd_ctrl.sv =====
// Controller: sequences capture, correlation runs and the output beat.
// Depends on tupd_pkg.
`timescale 1ns / 1ps

module tupd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 in_cmd,
	output tupd_pkg::tupd_ctl_t  ctl,
	input  tupd_pkg::tupd_stat_t stat
);
	import tupd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_CORR_B1,
		S_CORR_A,
		S_CHECK_B,
		S_CORR_B2,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl = '0;
		case (state_q)
			S_IDLE: ctl.capture = in_valid;
			S_DECIDE: begin
				ctl.decide = 1'b1;
				if (stat.br_onlyb) begin
					if (stat.need_onlyb) begin
						ctl.corr_start = 1'b1;
						ctl.corr_user  = 1'b1;
					end else begin
						ctl.apply_onlyb = 1'b1;
					end
				end else if (stat.br_both && stat.need_a) begin
					ctl.corr_start = 1'b1;
				end
			end
			S_CORR_B1: begin
				ctl.apply_onlyb = stat.corr_done;
				ctl.apply_hit   = stat.corr_hit;
			end
			S_CORR_A: begin
				ctl.apply_a   = stat.corr_done;
				ctl.apply_hit = stat.corr_hit;
			end
			S_CHECK_B: begin
				ctl.corr_start = stat.need_b;
				ctl.corr_user  = 1'b1;
			end
			S_CORR_B2: begin
				ctl.apply_b   = stat.corr_done;
				ctl.apply_hit = stat.corr_hit;
			end
			S_FINISH: ctl.finish = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (in_cmd == CMD_LOAD) ? S_FINISH : S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (stat.br_onlyb) begin
						state_q <= stat.need_onlyb ? S_CORR_B1 : S_FINISH;
					end else if (stat.br_both) begin
						state_q <= stat.need_a ? S_CORR_A : S_CHECK_B;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_CORR_B1: if (stat.corr_done) state_q <= S_FINISH;
				S_CORR_A:  if (stat.corr_done) state_q <= S_CHECK_B;
				S_CHECK_B: state_q <= stat.need_b ? S_CORR_B2 : S_FINISH;
				S_CORR_B2: if (stat.corr_done) state_q <= S_FINISH;
				S_FINISH: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/two_user_preamble_peak_detector_unit.sv =====
// Two-user preamble peak detector: a preamble load goes from capture straight to the
// output update; a sample passes a decide state (and, in the A/B window phase, a B check
// state) before the output update, with at most two correlation runs per sample; a
// stalled result holds the next beat in its finish state until the output slot frees.
// One beat is in flight at a time; the output register lets the next beat enter
// while a result waits. The correlation MAC (one window entry per cycle) and the
// bit-serial energy multiplier make up each correlation run. Async active-low reset clears state.
`timescale 1ns / 1ps

module two_user_preamble_peak_detector_unit #(
	parameter int PREAMBLE_LEN = tupd_pkg::PREAMBLE_LEN_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 cmd,
	input  logic                                 auto_peak,
	input  logic signed [tupd_pkg::SAMPLE_W-1:0] sample_re,
	input  logic signed [tupd_pkg::SAMPLE_W-1:0] sample_im,
	input  logic signed [tupd_pkg::SAMPLE_W-1:0] cfo_in,
	input  logic                                 table_sel,
	input  logic [tupd_pkg::TIDX_W-1:0]          table_index,
	input  logic signed [tupd_pkg::SAMPLE_W-1:0] coef_re,
	input  logic signed [tupd_pkg::SAMPLE_W-1:0] coef_im,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           peak_mode,
	output logic [1:0]                           tag_kind,
	output logic signed [tupd_pkg::SAMPLE_W-1:0] cfo_out,
	// configuration writes, to be made only while idle; the block does not enforce this
	input  logic                                 cfg_we,
	input  logic [tupd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tupd_pkg::CFG_W-1:0]           cfg_data
);
	import tupd_pkg::*;

	tupd_ctl_t  ctl;
	tupd_stat_t stat;

	// Controller: walks each beat through capture, the B-only or A-then-B
	// correlation windows, and the final output update.
	tupd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.in_cmd   (cmd),
		.ctl      (ctl),
		.stat     (stat)
	);

	// Datapath: holds the sliding window, both preambles, the search
	// bookkeeping and the output payload registers.
	tupd_dp #(.N(PREAMBLE_LEN)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.auto_peak  (auto_peak),
		.sample_re  (sample_re),
		.sample_im  (sample_im),
		.cfo_in     (cfo_in),
		.table_sel  (table_sel),
		.table_index(table_index),
		.coef_re    (coef_re),
		.coef_im    (coef_im),
		.peak_mode  (peak_mode),
		.tag_kind   (tag_kind),
		.cfo_out    (cfo_out)
	);

endmodule

// ===== rtl/core/tupd_checker.sv =====
// Port-level checker for the peak detector, bound to the top level.
// Depends on tupd_pkg.
`timescale 1ns / 1ps

module tupd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] peak_mode,
	input logic [1:0] tag_kind
);
	import tupd_pkg::*;

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// one beat at a time: stall right after an accept
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat accepted back to back");

	a_multi_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tag_kind == TAG_MULTI) |-> (peak_mode == MODE_BOTH))
		else $error("multi-user tag without both users");

	a_no_mode_no_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (peak_mode == MODE_NONE) |-> (tag_kind == TAG_NONE))
		else $error("tag without detected mode");

endmodule

bind two_user_preamble_peak_detector_unit tupd_checker u_tupd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.peak_mode(peak_mode),
	.tag_kind (tag_kind)
);
